@@ hdl/ctq_pkg.sv @@
// ctq_pkg: types, constants and helpers shared by the conic subdivider.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none
package ctq_pkg;

	localparam int MAX_LEVELS = 5;
	localparam int LEVEL_CAP  = 5;
	localparam int ONE_Q16    = 65536;
	localparam int DIV_W      = 54;
	localparam int LVL_W      = 3;
	localparam int TOL_RESET  = 16384;
	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] ctrl_x;
		logic signed [31:0] ctrl_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic        [31:0] conic_weight;
	} in_t;

	typedef struct packed {
		logic signed [31:0] seg_start_x;
		logic signed [31:0] seg_start_y;
		logic signed [31:0] seg_ctrl_x;
		logic signed [31:0] seg_ctrl_y;
		logic signed [31:0] seg_end_x;
		logic signed [31:0] seg_end_y;
		logic               last_segment;
		logic        [5:0]  segment_total;
	} out_t;

	// classified request handed from front to back
	typedef struct packed {
		in_t              conic;
		logic [LVL_W-1:0] lvl;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

@@ hdl/ctq_div.sv @@
// ctq_div: restoring divider, one quotient bit per cycle.
// Depends on ctq_pkg.
`default_nettype none
module ctq_div import ctq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [32:0]      den,
	output logic                  busy,
	output logic [DIV_W-1:0]      quo
);
	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [32:0]      den_q;
	logic [33:0]      rem_q;
	logic [33:0]      trial;
	logic             ge;

	assign trial = {rem_q[32:0], num_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[DIV_W-2:0], ge};
			num_q <= {num_q[DIV_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

@@ hdl/ctq_sqrt.sv @@
// ctq_sqrt: integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on ctq_pkg.
`default_nettype none
module ctq_sqrt import ctq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] op,
	output logic             busy,
	output logic [31:0]      root
);
	logic        busy_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] b_q;
	logic [63:0] rb;

	assign rb = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (busy_q && b_q[0])
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= op;
			r_q <= '0;
			b_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[31:0];
endmodule
`default_nettype wire

@@ hdl/ctq_front.sv @@
// ctq_front: takes a conic request, works out its level count and queues it.
// Depends on ctq_pkg, ctq_div, ctq_sqrt.
`default_nettype none
module ctq_front import ctq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	input  wire logic [31:0] tolerance,
	input  wire q_stat_t     qstat,
	output logic             push,
	output job_t             job
);
	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_SQ   = 3'd1;
	localparam logic [2:0] F_RT   = 3'd2;
	localparam logic [2:0] F_WAIT = 3'd3;
	localparam logic [2:0] F_MUL  = 3'd4;
	localparam logic [2:0] F_LVL  = 3'd5;

	logic [2:0]        state_q;
	in_t               conic_q;
	logic [30:0]       ax_q, ay_q;
	logic [1:0]        sh_q;
	logic [61:0]       sqx_q, sqy_q;
	logic [33:0]       err_q;

	logic signed [33:0] dx, dy;
	logic [33:0]        ax, ay, top;
	logic [1:0]         sh;
	logic [31:0]        wnum;
	logic               accept;
	logic               div_busy, sq_busy;
	logic [DIV_W-1:0]   quo;
	logic [31:0]        root;
	logic [34:0]        len;
	logic [57:0]        prod;
	logic [LVL_W-1:0]   lvl;

	assign accept = in_valid && (state_q == F_IDLE);
	assign in_ready = (state_q == F_IDLE);

	assign dx = 34'(in_data.start_x) - (34'(in_data.ctrl_x) <<< 1) + 34'(in_data.end_x);
	assign dy = 34'(in_data.start_y) - (34'(in_data.ctrl_y) <<< 1) + 34'(in_data.end_y);
	assign ax = dx[33] ? 34'(-dx) : 34'(dx);
	assign ay = dy[33] ? 34'(-dy) : 34'(dy);
	assign top = ax | ay;
	always_comb begin
		if (top[33])      sh = 2'd3;
		else if (top[32]) sh = 2'd2;
		else if (top[31]) sh = 2'd1;
		else              sh = 2'd0;
	end

	assign wnum = (in_data.conic_weight >= 32'(ONE_Q16)) ?
		in_data.conic_weight - 32'(ONE_Q16) : 32'(ONE_Q16) - in_data.conic_weight;

	ctq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.num({wnum, 22'd0}),
		.den(33'(in_data.conic_weight) + 33'(ONE_Q16)),
		.busy(div_busy), .quo(quo)
	);

	ctq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(state_q == F_RT),
		.op(64'(sqx_q) + 64'(sqy_q)),
		.busy(sq_busy), .root(root)
	);

	assign len  = 35'(root) << sh_q;
	assign prod = 58'(len) * 58'(quo[22:0]);

	// quarter the error until it fits, at most MAX_LEVELS times; none at zero tolerance
	always_comb begin
		lvl = '0;
		if (tolerance != '0)
			for (int i = 0; i < MAX_LEVELS; i++)
				if ((err_q >> (2 * i)) > 34'(tolerance))
					lvl = lvl + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (accept) state_q <= F_SQ;
				F_SQ:   state_q <= F_RT;
				F_RT:   state_q <= F_WAIT;
				F_WAIT: if (!div_busy && !sq_busy) state_q <= F_MUL;
				F_MUL:  state_q <= F_LVL;
				F_LVL:  if (!qstat.full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			conic_q <= in_data;
			ax_q    <= 31'(ax >> sh);
			ay_q    <= 31'(ay >> sh);
			sh_q    <= sh;
		end
		if (state_q == F_SQ) begin
			sqx_q <= 62'(ax_q) * 62'(ax_q);
			sqy_q <= 62'(ay_q) * 62'(ay_q);
		end
		if (state_q == F_MUL)
			err_q <= prod[57:24];
	end

	assign push      = (state_q == F_LVL) && !qstat.full;
	assign job.conic = conic_q;
	assign job.lvl   = lvl;
endmodule
`default_nettype wire

@@ hdl/ctq_fifo.sv @@
// ctq_fifo: short request queue between the classifier and the subdivider.
// Depends on ctq_pkg.
`default_nettype none
module ctq_fifo import ctq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output q_stat_t   qstat
);
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	assign rd_job      = mem_q[rp_q];
	assign qstat.full  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign qstat.empty = (cnt_q == '0);
endmodule
`default_nettype wire

@@ hdl/ctq_back.sv @@
// ctq_back: depth-first conic halving and segment output register.
// Depends on ctq_pkg, ctq_div, ctq_sqrt.
`default_nettype none
module ctq_back import ctq_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t qstat,
	input  wire job_t    job,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_ready,
	output out_t         out_data
);
	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SPLIT = 3'd1;
	localparam logic [2:0] B_WAIT  = 3'd2;
	localparam logic [2:0] B_APPLY = 3'd3;
	localparam logic [2:0] B_EMIT  = 3'd4;
	localparam logic [2:0] B_DEG0  = 3'd5;
	localparam logic [2:0] B_DEG1  = 3'd6;
	localparam int NL = 6;

	function automatic logic betw(logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c);
		return (a <= b && b <= c) || (c <= b && b <= a);
	endfunction

	logic [2:0]         state_q;
	in_t                cur_q;
	in_t                slot_q [LEVEL_CAP];
	logic [2:0]         r_q;
	logic [5:0]         emitted_q, total_q;
	logic               chk_q;
	logic signed [31:0] prev_x_q, prev_y_q;
	logic signed [31:0] dc_x_q, dc_y_q;
	logic [NL-1:0]      neg_q;
	logic               out_valid_q;
	out_t               out_q;

	logic signed [48:0] nm [NL];
	logic [DIV_W-1:0]   mag [NL];
	logic [DIV_W-1:0]   quo [NL];
	logic [NL-1:0]      dbusy;
	logic               sq_busy;
	logic [31:0]        nw;
	logic signed [31:0] p1 [NL];
	logic signed [31:0] res [NL];
	logic               start;
	logic               can_load;
	logic               load;
	logic               deg;
	logic signed [31:0] my, ay1, by1, cl;
	logic [32:0]        d_s, d_e;
	logic [5:0]         nxt_em;
	logic [2:0]         tz;
	logic [2:0]         ncap;
	in_t                a_c, b_c;

	assign start    = (state_q == B_SPLIT);
	assign can_load = !out_valid_q || out_ready;
	assign load     = can_load && (state_q inside {B_EMIT, B_DEG0, B_DEG1});

	// lanes: mid x/y, left control x/y, right control x/y
	always_comb begin
		nm[0] = ((49'(cur_q.start_x) + 49'(cur_q.end_x)) <<< 15) - (49'(cur_q.ctrl_x) <<< 16);
		nm[1] = ((49'(cur_q.start_y) + 49'(cur_q.end_y)) <<< 15) - (49'(cur_q.ctrl_y) <<< 16);
		nm[2] = (49'(cur_q.start_x) - 49'(cur_q.ctrl_x)) <<< 16;
		nm[3] = (49'(cur_q.start_y) - 49'(cur_q.ctrl_y)) <<< 16;
		nm[4] = (49'(cur_q.end_x) - 49'(cur_q.ctrl_x)) <<< 16;
		nm[5] = (49'(cur_q.end_y) - 49'(cur_q.ctrl_y)) <<< 16;
		for (int i = 0; i < NL; i++) begin
			mag[i] = DIV_W'(nm[i][48] ? 49'(-nm[i]) : 49'(nm[i]));
			p1[i]  = i[0] ? cur_q.ctrl_y : cur_q.ctrl_x;
		end
	end

	for (genvar g = 0; g < NL; g++) begin : g_lane
		logic [33:0] sq;
		ctq_div u_div (
			.clk(clk), .arst_n(arst_n), .start(start), .num(mag[g]),
			.den(33'(cur_q.conic_weight) + 33'(ONE_Q16)),
			.busy(dbusy[g]), .quo(quo[g])
		);
		// truncation toward zero: divide magnitudes, then restore sign
		assign sq = neg_q[g] ? 34'(-{1'b0, quo[g][32:0]}) : {1'b0, quo[g][32:0]};
		assign res[g] = 32'(35'(p1[g]) + 35'($signed(sq)));
	end

	ctq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(start),
		.op(64'((33'(ONE_Q16) + 33'(cur_q.conic_weight)) >> 1) << 16),
		.busy(sq_busy), .root(nw)
	);

	assign deg = (res[2] == res[0]) && (res[3] == res[1]) &&
		(res[0] == res[4]) && (res[1] == res[5]);

	// halves with y-monotonic clamping
	always_comb begin
		my  = res[1];
		ay1 = res[3];
		by1 = res[5];
		d_s = 33'(my) - 33'(cur_q.start_y);
		d_e = 33'(my) - 33'(cur_q.end_y);
		d_s = d_s[32] ? 33'(-d_s) : d_s;
		d_e = d_e[32] ? 33'(-d_e) : d_e;
		cl  = (d_s < d_e) ? cur_q.start_y : cur_q.end_y;
		if (betw(cur_q.start_y, cur_q.ctrl_y, cur_q.end_y)) begin
			if (!betw(cur_q.start_y, my, cur_q.end_y))
				my = cl;
			if (!betw(cur_q.start_y, ay1, my))
				ay1 = cur_q.start_y;
			if (!betw(my, by1, cur_q.end_y))
				by1 = cur_q.end_y;
		end
		a_c = '{start_x: cur_q.start_x, start_y: cur_q.start_y, ctrl_x: res[2],
			ctrl_y: ay1, end_x: res[0], end_y: my, conic_weight: nw};
		b_c = '{start_x: res[0], start_y: my, ctrl_x: res[4], ctrl_y: by1,
			end_x: cur_q.end_x, end_y: cur_q.end_y, conic_weight: nw};
	end

	assign nxt_em = emitted_q + 1'b1;
	always_comb begin
		tz = '0;
		for (int i = LEVEL_CAP - 1; i >= 0; i--)
			if (nxt_em[i]) tz = 3'(i);
	end

	assign ncap = (job.lvl > LVL_W'(LEVEL_CAP)) ? LVL_W'(LEVEL_CAP) : job.lvl;
	assign pop  = (state_q == B_IDLE) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !out_ready);
			case (state_q)
				B_IDLE: if (pop)
					state_q <= (ncap != '0) ? B_SPLIT : B_EMIT;
				B_SPLIT: state_q <= B_WAIT;
				B_WAIT: if (dbusy == '0 && !sq_busy) state_q <= B_APPLY;
				B_APPLY: begin
					if (chk_q && deg)  state_q <= B_DEG0;
					else if (r_q == 3'd1) state_q <= B_EMIT;
					else               state_q <= B_SPLIT;
				end
				B_EMIT: if (can_load) begin
					if (nxt_em == total_q)  state_q <= B_IDLE;
					else if (tz == '0)      state_q <= B_EMIT;
					else                    state_q <= B_SPLIT;
				end
				B_DEG0: if (can_load) state_q <= B_DEG1;
				B_DEG1: if (can_load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cur_q     <= job.conic;
				r_q       <= ncap;
				total_q   <= 6'd1 << ncap;
				emitted_q <= '0;
				chk_q     <= job.lvl >= LVL_W'(MAX_LEVELS);
				prev_x_q  <= job.conic.start_x;
				prev_y_q  <= job.conic.start_y;
			end
			B_SPLIT: for (int i = 0; i < NL; i++) neg_q[i] <= nm[i][48];
			B_APPLY: begin
				if (chk_q && deg) begin
					dc_x_q <= res[2];
					dc_y_q <= res[3];
				end else begin
					slot_q[r_q - 1'b1] <= b_c;
					cur_q <= a_c;
					r_q   <= r_q - 1'b1;
				end
				chk_q <= 1'b0;
			end
			B_EMIT: if (can_load) begin
				out_q <= '{seg_start_x: prev_x_q, seg_start_y: prev_y_q,
					seg_ctrl_x: cur_q.ctrl_x, seg_ctrl_y: cur_q.ctrl_y,
					seg_end_x: cur_q.end_x, seg_end_y: cur_q.end_y,
					last_segment: nxt_em == total_q, segment_total: total_q};
				prev_x_q  <= cur_q.end_x;
				prev_y_q  <= cur_q.end_y;
				emitted_q <= nxt_em;
				cur_q     <= slot_q[tz];
				r_q       <= tz;
			end
			B_DEG0: if (can_load)
				out_q <= '{seg_start_x: cur_q.start_x, seg_start_y: cur_q.start_y,
					seg_ctrl_x: dc_x_q, seg_ctrl_y: dc_y_q,
					seg_end_x: dc_x_q, seg_end_y: dc_y_q,
					last_segment: 1'b0, segment_total: 6'd2};
			B_DEG1: if (can_load)
				out_q <= '{seg_start_x: dc_x_q, seg_start_y: dc_y_q,
					seg_ctrl_x: dc_x_q, seg_ctrl_y: dc_y_q,
					seg_end_x: cur_q.end_x, seg_end_y: cur_q.end_y,
					last_segment: 1'b1, segment_total: 6'd2};
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

@@ hdl/conic_to_quadratics.sv @@
// conic_to_quadratics: top level of the conic-to-quadratic subdivider.
// Depends on ctq_pkg, ctq_front, ctq_fifo, ctq_back.
//
// channel   signals                        request
// -------   ----------------------------   -------------------------------
// in        in_valid/in_ready/in_data      one conic: 3 points + weight
// out       out_valid/out_ready/out_data   one quadratic segment
// cfg       cfg_we/cfg_wdata               tolerance, unsigned Q16.16
//
// Front: one request at a time; a divider for k and an isqrt run alongside.
// Back: each split waits on the six lane dividers run in parallel;
// up to 31 splits, so 32 segments at most.
// A two-entry queue lets the front classify the next request meanwhile.
// The output register holds a segment while the back keeps working.
// Reset is asynchronous; the tolerance resets to 0.25.
`default_nettype none
module conic_to_quadratics import ctq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	logic [31:0] tol_q;
	logic        push, pop;
	job_t        wr_job, rd_job;
	q_stat_t     qstat;

	// tolerance register; the user writes it only while the block is idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= 32'(TOL_RESET);
		else if (cfg_we)
			tol_q <= cfg_wdata;
	end

	ctq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.tolerance(tol_q), .qstat(qstat), .push(push), .job(wr_job)
	);

	ctq_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_job(wr_job), .pop(pop), .rd_job(rd_job), .qstat(qstat)
	);

	ctq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.qstat(qstat), .job(rd_job), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for conic_to_quadratics (conic in, quadratic segments out).
// Depends on ctq_pkg and the RTL in hdl/; holds its own subdivision predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import ctq_pkg::*;

	// a conic held at full precision while it is being halved
	typedef struct {
		longint x[3];
		longint y[3];
		longint unsigned w;
	} arc_t;

	// one row of the directed table; 'typed' rows carry a single
	// segment equal to the input conic as the known answer
	typedef struct {
		logic [31:0] tol;
		in_t         c;
		bit          typed;
	} row_t;

	localparam int WATCHDOG = 30000;  // cycles with no request moving

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	conic_to_quadratics dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state: its own copy of the tolerance register
	logic [31:0] tol_shadow;
	out_t        seg_q[$];      // segments still owed by the block
	int          mismatches = 0;
	int          idle_cycles;
	bit          typed_next;    // current request has a hand-typed answer
	bit          calm;          // no idling on either side
	row_t        rows[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic bit between(longint a, longint b, longint c);
		return (a <= b && b <= c) || (c <= b && b <= a);
	endfunction

	// levels needed: error quartered per level until within tolerance; none at zero tolerance
	function automatic int levels_needed(arc_t c);
		longint unsigned ax, ay, num, k24, err;
		int s, n;
		s = 0;
		n = 0;
		if (tol_shadow == 0) return 0;
		ax = mag(c.x[0] - 2 * c.x[1] + c.x[2]);
		ay = mag(c.y[0] - 2 * c.y[1] + c.y[2]);
		while ((ax >> s) >= 64'h8000_0000 || (ay >> s) >= 64'h8000_0000) s++;
		ax >>= s;
		ay >>= s;
		num = (c.w >= ONE_Q16) ? c.w - ONE_Q16 : ONE_Q16 - c.w;
		k24 = (num << 22) / (c.w + ONE_Q16);
		err = ((isqrt(ax * ax + ay * ay) << s) * k24) >> 24;
		while (n < MAX_LEVELS) begin
			if (err <= tol_shadow) break;
			err >>= 2;
			n++;
		end
		return n;
	endfunction

	// halve a conic; divisions truncate toward zero as SV signed '/' does
	function automatic void halve(arc_t c, output arc_t a, output arc_t b);
		longint d, mx, my;
		longint unsigned nw;
		d  = longint'(c.w + ONE_Q16);
		nw = isqrt(((ONE_Q16 + c.w) >> 1) * ONE_Q16);
		mx = c.x[1] + ((c.x[0] + c.x[2]) * 32768 - c.x[1] * ONE_Q16) / d;
		my = c.y[1] + ((c.y[0] + c.y[2]) * 32768 - c.y[1] * ONE_Q16) / d;
		a.x[0] = c.x[0];
		a.y[0] = c.y[0];
		a.x[1] = c.x[1] + ((c.x[0] - c.x[1]) * ONE_Q16) / d;
		a.y[1] = c.y[1] + ((c.y[0] - c.y[1]) * ONE_Q16) / d;
		a.x[2] = mx;
		a.y[2] = my;
		b.x[0] = mx;
		b.y[0] = my;
		b.x[1] = c.x[1] + ((c.x[2] - c.x[1]) * ONE_Q16) / d;
		b.y[1] = c.y[1] + ((c.y[2] - c.y[1]) * ONE_Q16) / d;
		b.x[2] = c.x[2];
		b.y[2] = c.y[2];
		a.w = nw;
		b.w = nw;
	endfunction

	// halve, then keep a y-monotonic conic y-monotonic
	function automatic void halve_clamped(arc_t c, output arc_t a, output arc_t b);
		longint sy, ey, my, cl;
		sy = c.y[0];
		ey = c.y[2];
		halve(c, a, b);
		if (between(sy, c.y[1], ey)) begin
			my = a.y[2];
			if (!between(sy, my, ey)) begin
				cl = (mag(my - sy) < mag(my - ey)) ? sy : ey;
				a.y[2] = cl;
				b.y[0] = cl;
			end
			if (!between(sy, a.y[1], a.y[2])) a.y[1] = sy;
			if (!between(b.y[0], b.y[1], ey)) b.y[1] = ey;
		end
	endfunction

	function automatic out_t make_seg(longint sx, longint sy, longint cx, longint cy,
			longint ex, longint ey, bit last, int total);
		out_t o;
		o.seg_start_x   = sx[31:0];
		o.seg_start_y   = sy[31:0];
		o.seg_ctrl_x    = cx[31:0];
		o.seg_ctrl_y    = cy[31:0];
		o.seg_end_x     = ex[31:0];
		o.seg_end_y     = ey[31:0];
		o.last_segment  = last;
		o.segment_total = total[5:0];
		return o;
	endfunction

	// all segments of one conic, appended in output order
	function automatic void predict_segments(in_t req);
		arc_t cur, a, b;
		arc_t held[LEVEL_CAP];
		longint px, py;
		int n, total, r, done;
		cur.x[0] = req.start_x;
		cur.y[0] = req.start_y;
		cur.x[1] = req.ctrl_x;
		cur.y[1] = req.ctrl_y;
		cur.x[2] = req.end_x;
		cur.y[2] = req.end_y;
		cur.w    = req.conic_weight;
		n = levels_needed(cur);
		if (n >= MAX_LEVELS) begin
			halve(cur, a, b);
			// halves collapsed onto one point: two segments through it
			if (a.x[1] == a.x[2] && a.y[1] == a.y[2] &&
					b.x[0] == b.x[1] && b.y[0] == b.y[1]) begin
				seg_q.push_back(make_seg(cur.x[0], cur.y[0], a.x[1], a.y[1],
					a.x[1], a.y[1], 1'b0, 2));
				seg_q.push_back(make_seg(a.x[1], a.y[1], a.x[1], a.y[1],
					b.x[2], b.y[2], 1'b1, 2));
				return;
			end
		end
		if (n > LEVEL_CAP) n = LEVEL_CAP;
		total = 1 << n;
		r = n;
		done = 0;
		px = cur.x[0];
		py = cur.y[0];
		forever begin
			// go down the left side, parking each right half by level
			while (r > 0) begin
				halve_clamped(cur, a, b);
				held[(r - 1) % LEVEL_CAP] = b;
				cur = a;
				r--;
			end
			done++;
			seg_q.push_back(make_seg(px, py, cur.x[1], cur.y[1], cur.x[2], cur.y[2],
				done == total, total));
			px = cur.x[2];
			py = cur.y[2];
			if (done >= total) break;
			r = 0;
			while (((done >> r) & 1) == 0) r++;
			cur = held[r % LEVEL_CAP];
		end
	endfunction

	// ---------------------------------------------------------------
	// Monitors: everything sampled at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		out_t want;
		if (!arst_n) begin
			tol_shadow  <= TOL_RESET;
			idle_cycles <= 0;
		end else begin
			if (cfg_we) tol_shadow <= cfg_wdata;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_valid && in_ready) begin
				if (typed_next)
					seg_q.push_back(make_seg(in_data.start_x, in_data.start_y,
						in_data.ctrl_x, in_data.ctrl_y, in_data.end_x, in_data.end_y,
						1'b1, 1));
				else
					predict_segments(in_data);
			end
			if (out_valid && out_ready) begin
				if (seg_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected segment %p", out_data);
				end else begin
					want = seg_q.pop_front();
					if (out_data.seg_start_x !== want.seg_start_x ||
							out_data.seg_start_y !== want.seg_start_y ||
							out_data.seg_ctrl_x !== want.seg_ctrl_x ||
							out_data.seg_ctrl_y !== want.seg_ctrl_y ||
							out_data.seg_end_x !== want.seg_end_x ||
							out_data.seg_end_y !== want.seg_end_y ||
							out_data.last_segment !== want.last_segment ||
							out_data.segment_total !== want.segment_total) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: segment mismatch");
							$display("  expected %p", want);
							$display("  actual   %p", out_data);
						end
					end
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: nothing moved for %0d cycles", WATCHDOG);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pause_len();
		if (calm) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 2);
	endfunction

	// receiver stalls at random, except in calm stretches
	always @(negedge clk) begin
		if (!arst_n || calm) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 15) == 0) ? 1'b0 :
			($urandom_range(0, 3) != 0);
	end

	// one request; called and left at a falling edge
	task automatic send_conic(in_t c, bit typed);
		int g;
		g = pause_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		typed_next <= typed;
		in_data    <= c;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// tolerance may only change with the block idle
	task automatic set_tolerance(logic [31:0] v);
		in_valid <= 1'b0;
		while (seg_q.size() != 0) @(posedge clk);
		repeat (50) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] small_coord();
		return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
	endfunction

	function automatic in_t random_conic();
		in_t c;
		logic [31:0] t;
		if ($urandom_range(0, 9) < 2) begin
			// full-range noise: every bit of every field gets exercised
			c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return c;
		end
		c.start_x = small_coord();
		c.start_y = small_coord();
		c.ctrl_x  = small_coord();
		c.ctrl_y  = small_coord();
		c.end_x   = small_coord();
		c.end_y   = small_coord();
		// half the conics y-monotonic, so clamping is reached
		if ($urandom_range(0, 1)) begin
			if ($signed(c.start_y) > $signed(c.end_y)) begin
				t = c.start_y;
				c.start_y = c.end_y;
				c.end_y = t;
			end
			if ($signed(c.ctrl_y) < $signed(c.start_y)) c.ctrl_y = c.start_y;
			if ($signed(c.ctrl_y) > $signed(c.end_y)) c.ctrl_y = c.end_y;
		end
		case ($urandom_range(0, 4))
			0: c.conic_weight = 32'd0;
			1: c.conic_weight = ONE_Q16 + $urandom_range(0, 64) - 32;
			2: c.conic_weight = $urandom_range(0, 32'h0004_0000);
			3: c.conic_weight = $urandom_range(0, 32'h0000_4000);
			default: c.conic_weight = $urandom;
		endcase
		return c;
	endfunction

	function automatic row_t mk_row(logic [31:0] tol, logic [31:0] sx, logic [31:0] sy,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] ex, logic [31:0] ey,
			logic [31:0] w, bit typed);
		row_t r;
		r.tol   = tol;
		r.c     = {sx, sy, cx, cy, ex, ey, w};
		r.typed = typed;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		logic [31:0] cur_tol;
		logic [31:0] phase_tol[4];
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		typed_next = 1'b0;
		calm       = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset tolerance: flat weight and a straight line need no split; the other two rows split
		rows.push_back(mk_row(TOL_RESET, 32'h0001_0000, 32'h0002_0000, 32'h0005_0000,
			32'hFFFF_0000, 32'h0003_0000, 32'h0000_8000, ONE_Q16, 1'b1));
		rows.push_back(mk_row(TOL_RESET, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000, 1'b1));
		rows.push_back(mk_row(TOL_RESET, 32'h0000_0000, 32'h0000_0000, 32'h0008_0000,
			32'h0010_0000, 32'h0010_0000, 32'h0000_0000, 32'h0002_0000, 1'b0));
		rows.push_back(mk_row(TOL_RESET, 32'h0000_0000, 32'h0000_0000, 32'h0004_0000,
			32'h0008_0000, 32'h0008_0000, 32'h000A_0000, 32'h0000_8000, 1'b0));
		// zero tolerance: one segment equal to the conic, extremes included
		rows.push_back(mk_row(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		rows.push_back(mk_row(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1));
		rows.push_back(mk_row(32'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678,
			32'hEDCB_A987, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1));
		// tolerance 1: deepest subdivision, and the collapsed first split
		rows.push_back(mk_row(32'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_8000,
			32'h0000_8000, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
		rows.push_back(mk_row(32'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0));
		rows.push_back(mk_row(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		rows.push_back(mk_row(32'd1, 32'h0000_0000, 32'h0000_0000, 32'h0010_0000,
			32'h0020_0000, 32'h0030_0000, 32'h0040_0000, 32'h0000_0000, 1'b0));
		rows.push_back(mk_row(32'd1, 32'h0000_0000, 32'h0010_0000, 32'h0005_0000,
			32'h0100_0000, 32'h000A_0000, 32'h0011_0000, 32'h0003_0000, 1'b0));
		// widest tolerance: never subdivides
		rows.push_back(mk_row(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_0000,
			32'h8000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
		rows.push_back(mk_row(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000, 1'b1));

		cur_tol = TOL_RESET;
		@(negedge clk);
		foreach (rows[i]) begin
			// the reset value is written back explicitly once, too
			if (i == 1 || rows[i].tol !== cur_tol) begin
				set_tolerance(rows[i].tol);
				cur_tol = rows[i].tol;
			end
			send_conic(rows[i].c, rows[i].typed);
		end

		// random part: a few tolerance phases, one of them without idling
		phase_tol[0] = $urandom_range(1, 32'h0001_0000);
		phase_tol[1] = 32'd1;
		phase_tol[2] = $urandom;
		phase_tol[3] = TOL_RESET;
		for (int p = 0; p < 4; p++) begin
			set_tolerance(phase_tol[p]);
			calm = (p == 2);
			for (int k = 0; k < 29; k++) send_conic(random_conic(), 1'b0);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (seg_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && seg_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
